// File: hw/rtl/bank_mapper_scanline_irq_macros.svh
// Assertion helpers shared by the mapper RTL.
`ifndef BANK_MAPPER_SCANLINE_IRQ_MACROS_SVH
`define BANK_MAPPER_SCANLINE_IRQ_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bank mapper check failed");

// Next-cycle implication, checked outside reset.
`define BMSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bank mapper check failed");

`endif

// File: hw/rtl/bmsi_pkg.sv
package bmsi_pkg;

    // Target memory codes
    localparam logic [2:0] TGT_NONE       = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM    = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM    = 3'd2;
    localparam logic [2:0] TGT_PATTERN    = 3'd3;
    localparam logic [2:0] TGT_FOUR_SCR   = 3'd4;

    // Mirroring codes
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIRROR_FOUR       = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

    // Mapper register decode: {address[14:13], address[0]} in 0x8000-0xFFFF
    localparam logic [2:0] REG_BANK_SELECT = 3'b000;
    localparam logic [2:0] REG_BANK_DATA   = 3'b001;
    localparam logic [2:0] REG_MIRROR      = 3'b010;
    localparam logic [2:0] REG_RAM_PROTECT = 3'b011;
    localparam logic [2:0] REG_IRQ_PERIOD  = 3'b100;
    localparam logic [2:0] REG_IRQ_RELOAD  = 3'b101;
    localparam logic [2:0] REG_IRQ_DISABLE = 3'b110;
    localparam logic [2:0] REG_IRQ_ENABLE  = 3'b111;

    // Fixed program banks
    localparam logic [7:0] PRG_FIXED_LOW  = 8'hFE;
    localparam logic [7:0] PRG_FIXED_LAST = 8'hFF;

    // Configuration reset values
    localparam logic [6:0] PRG_COUNT_RESET = 7'd64;
    localparam logic [8:0] CHR_COUNT_RESET = 9'd256;

    typedef logic [7:0] t_byte;

endpackage

// File: hw/rtl/bank_mapper_scanline_irq.sv
// Chan | Handshake               | Payload
// -----+-------------------------+-----------------------------------------------------------
// in   | i_in_valid/o_in_ready   | i_command i_address i_write_data
// out  | o_out_valid/i_out_ready | o_target o_mapped_address o_mem_write o_irq_line o_mirroring
// cfg  | i_cfg_we, no wait       | i_cfg_index i_cfg_data
//
// Flow: an item sits in the input register after its accept edge and moves to the
// result register once that register is empty or being drained; o_out_valid rises as it lands.
// One item per clock sustained while i_out_ready stays high, set by the single mapping stage.
// Reset: synchronous, active low; clears all mapper state, the config registers
// to their defaults and both valid flags. No clearing pass.
// Stalls: the input register keeps taking items while it is empty, or while the result
// register is empty or being drained in the same cycle; o_in_ready depends on i_out_ready.

`include "bank_mapper_scanline_irq_macros.svh"

module bank_mapper_scanline_irq
    import bmsi_pkg::*;
#(
    parameter int MAX_PRG_BANKS = 64,
    parameter int MAX_CHR_BANKS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_target,
    output logic [18:0] o_mapped_address,
    output logic        o_mem_write,
    output logic        o_irq_line,
    output logic [1:0]  o_mirroring
);

    // Bank numbers never exceed the build-time bank limit.
    localparam logic [7:0] PRG_MAX_MASK = 8'(MAX_PRG_BANKS - 1);
    localparam logic [7:0] CHR_MAX_MASK = 8'(MAX_CHR_BANKS - 1);

    // Configuration registers
    logic [6:0] r_prg_count;
    logic [8:0] r_chr_count;
    logic       r_four_screen;

    // Input register
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [15:0] r_in_addr;
    t_byte       r_in_data;

    // Mapper state
    t_byte r_bank_select;
    t_byte r_bank [8];
    logic  r_mirror;
    t_byte r_ram_protect;
    t_byte r_irq_reload;
    t_byte r_irq_count;
    logic  r_irq_enable;
    logic  r_a12_prev;
    logic  r_irq_pending;

    t_byte n_bank_select;
    t_byte n_bank [8];
    logic  n_mirror;
    t_byte n_ram_protect;
    t_byte n_irq_reload;
    t_byte n_irq_count;
    logic  n_irq_enable;
    logic  n_a12_prev;
    logic  n_irq_pending;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_target;
    logic [18:0] r_mapped;
    logic        r_mem_write;
    logic        r_irq_line;
    logic [1:0]  r_mirroring;

    logic [2:0]  n_target;
    logic [18:0] n_mapped;
    logic        n_mem_write;

    logic        w_adv;
    logic [7:0]  w_prg_mask;
    logic [8:0]  w_chr_m1;
    logic [7:0]  w_chr_mask;
    t_byte       w_prg_bank;
    logic [2:0]  w_chr_slot;
    logic [2:0]  w_chr_idx;
    t_byte       w_chr_raw;
    t_byte       w_chr_bank;
    t_byte       w_cnt_after;
    logic [2:0]  w_reg_sel;

    // Move the held item into the result register when that slot frees up.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // Bank masks: count minus one, taken in eight bits, so a zero count masks all ones.
    assign w_prg_mask = ({1'b0, r_prg_count} - 8'd1) & PRG_MAX_MASK;
    assign w_chr_m1   = r_chr_count - 9'd1;
    assign w_chr_mask = w_chr_m1[7:0] & CHR_MAX_MASK;

    // Program window bank: bit 6 of bank select swaps the first and third windows.
    always_comb begin
        case (r_in_addr[14:13])
            2'd0:    w_prg_bank = r_bank_select[6] ? PRG_FIXED_LOW : r_bank[6];
            2'd1:    w_prg_bank = r_bank[7];
            2'd2:    w_prg_bank = r_bank_select[6] ? r_bank[6] : PRG_FIXED_LOW;
            default: w_prg_bank = PRG_FIXED_LAST;
        endcase
    end

    // Pattern window bank: bit 7 of bank select swaps the 2 KiB and 1 KiB halves.
    // The 2 KiB windows use an even/odd pair of one bank register.
    assign w_chr_slot = r_in_addr[12:10] ^ {r_bank_select[7], 2'b00};
    assign w_chr_idx  = w_chr_slot[2] ? (3'({1'b0, w_chr_slot[1:0]}) + 3'd2)
                                      : {2'b00, w_chr_slot[1]};
    assign w_chr_raw  = r_bank[w_chr_idx];
    assign w_chr_bank = w_chr_slot[2] ? w_chr_raw : {w_chr_raw[7:1], w_chr_slot[0]};

    assign w_reg_sel  = {r_in_addr[14:13], r_in_addr[0]};

    // Scanline counter: reload on zero, else count down.
    assign w_cnt_after = (r_irq_count == 8'd0) ? r_irq_reload : r_irq_count - 8'd1;

    always_comb begin
        n_bank_select = r_bank_select;
        n_bank        = r_bank;
        n_mirror      = r_mirror;
        n_ram_protect = r_ram_protect;
        n_irq_reload  = r_irq_reload;
        n_irq_count   = r_irq_count;
        n_irq_enable  = r_irq_enable;
        n_a12_prev    = r_a12_prev;
        n_irq_pending = r_irq_pending;
        n_target      = TGT_NONE;
        n_mapped      = '0;
        n_mem_write   = 1'b0;

        if (r_in_addr[15:13] == 3'b000) begin
            // Pattern space; only reads watch A12.
            if (!r_in_cmd) begin
                n_a12_prev = r_in_addr[12];
                if (!r_a12_prev && r_in_addr[12]) begin
                    n_irq_count = w_cnt_after;
                    if (w_cnt_after == 8'd0 && r_irq_enable) begin
                        n_irq_pending = 1'b1;
                    end
                end
            end
            n_target    = TGT_PATTERN;
            n_mapped    = {1'b0, w_chr_bank & w_chr_mask, r_in_addr[9:0]};
            n_mem_write = r_in_cmd;
        end else if (r_in_addr[15:12] == 4'h2) begin
            // Name space: mapped only with four-screen RAM.
            if (r_four_screen) begin
                n_target    = TGT_FOUR_SCR;
                n_mapped    = {7'd0, r_in_addr[11:0]};
                n_mem_write = r_in_cmd;
            end
        end else if (r_in_addr[15:13] == 3'b011) begin
            // Program RAM: bit 7 enables, bit 6 refuses writes.
            if (r_ram_protect[7] && (!r_in_cmd || !r_ram_protect[6])) begin
                n_target    = TGT_PRG_RAM;
                n_mapped    = {6'd0, r_in_addr[12:0]};
                n_mem_write = r_in_cmd;
            end
        end else if (r_in_addr[15]) begin
            if (r_in_cmd) begin
                case (w_reg_sel)
                    REG_BANK_SELECT: n_bank_select = r_in_data;
                    REG_BANK_DATA:   n_bank[r_bank_select[2:0]] = r_in_data;
                    REG_MIRROR:      n_mirror = r_in_data[0];
                    REG_RAM_PROTECT: n_ram_protect = r_in_data;
                    REG_IRQ_PERIOD:  n_irq_reload = r_in_data;
                    REG_IRQ_RELOAD:  n_irq_count = 8'd0;
                    REG_IRQ_DISABLE: begin
                        n_irq_pending = 1'b0;
                        n_irq_enable  = 1'b0;
                    end
                    REG_IRQ_ENABLE:  n_irq_enable = 1'b1;
                    default:         n_irq_enable = r_irq_enable;
                endcase
            end else begin
                n_target = TGT_PRG_ROM;
                n_mapped = {(w_prg_bank[5:0] & w_prg_mask[5:0]), r_in_addr[12:0]};
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count   <= PRG_COUNT_RESET;
            r_chr_count   <= CHR_COUNT_RESET;
            r_four_screen <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRG_COUNT:   r_prg_count   <= i_cfg_data[6:0];
                CFG_CHR_COUNT:   r_chr_count   <= i_cfg_data;
                CFG_FOUR_SCREEN: r_four_screen <= i_cfg_data[0];
                default:         r_four_screen <= r_four_screen;
            endcase
        end
    end

    // Input register: load whenever the slot is free or drains this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_cmd  <= i_command;
            r_in_addr <= i_address;
            r_in_data <= i_write_data;
        end
    end

    // Mapper state: advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select <= '0;
            for (int i = 0; i < 8; i++) begin
                r_bank[i] <= '0;
            end
            r_mirror      <= 1'b0;
            r_ram_protect <= '0;
            r_irq_reload  <= '0;
            r_irq_count   <= '0;
            r_irq_enable  <= 1'b0;
            r_a12_prev    <= 1'b0;
            r_irq_pending <= 1'b0;
        end else if (w_adv) begin
            r_bank_select <= n_bank_select;
            r_bank        <= n_bank;
            r_mirror      <= n_mirror;
            r_ram_protect <= n_ram_protect;
            r_irq_reload  <= n_irq_reload;
            r_irq_count   <= n_irq_count;
            r_irq_enable  <= n_irq_enable;
            r_a12_prev    <= n_a12_prev;
            r_irq_pending <= n_irq_pending;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_target    <= n_target;
            r_mapped    <= n_mapped;
            r_mem_write <= n_mem_write;
            r_irq_line  <= n_irq_pending;
            r_mirroring <= r_four_screen ? MIRROR_FOUR
                         : (n_mirror ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_target         = r_target;
    assign o_mapped_address = r_mapped;
    assign o_mem_write      = r_mem_write;
    assign o_irq_line       = r_irq_line;
    assign o_mirroring      = r_mirroring;

    // A pending interrupt can only exist while enabled.
    `BMSI_ASSERT_NOW(a_pending_needs_enable, i_clk, i_rst_n, r_irq_pending, r_irq_enable)
    // The shown IRQ level tracks the state left by the last item.
    `BMSI_ASSERT_NOW(a_irq_matches_state, i_clk, i_rst_n, r_out_valid, r_irq_line == r_irq_pending)
    // An advancing item always lands in the result register.
    `BMSI_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    // Disable write drops both the pending flag and the enable.
    `BMSI_ASSERT_NEXT(a_disable_clears, i_clk, i_rst_n,
        w_adv && r_in_cmd && r_in_addr[15] && w_reg_sel == REG_IRQ_DISABLE,
        !r_irq_pending && !r_irq_enable)

endmodule

// File: bench/bank_mapper_scanline_irq_tb.sv
module bank_mapper_scanline_irq_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmsi_pkg::*;

    localparam int PRG_BANK_LIMIT = 64;
    localparam int CHR_BANK_LIMIT = 256;
    localparam int LONG_STALL     = 400;
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_bus_access;

    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] maddr;
        logic        wr;
        logic        irq;
        logic [1:0]  mirror;
    } t_map_result;

    // DUT-facing signals; the bench-driven inputs are known from time zero
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_index      = '0;
    logic [8:0]  i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic        i_command        = 1'b0;
    logic [15:0] i_address        = '0;
    logic [7:0]  i_write_data     = '0;
    logic        i_out_ready      = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_target;
    logic [18:0] o_mapped_address;
    logic        o_mem_write;
    logic        o_irq_line;
    logic [1:0]  o_mirroring;

    bank_mapper_scanline_irq #(
        .MAX_PRG_BANKS(PRG_BANK_LIMIT),
        .MAX_CHR_BANKS(CHR_BANK_LIMIT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_target        (o_target),
        .o_mapped_address(o_mapped_address),
        .o_mem_write     (o_mem_write),
        .o_irq_line      (o_irq_line),
        .o_mirroring     (o_mirroring)
    );

    // 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Mapper mirror: the bench's own copy of configuration and state.
    // Values match what reset leaves in the block.
    // ------------------------------------------------------------------
    logic [6:0] prg_cnt_cfg = PRG_COUNT_RESET;
    logic [8:0] chr_cnt_cfg = CHR_COUNT_RESET;
    logic       four_scr    = 1'b0;

    logic [7:0] sel_reg      = '0;
    logic [7:0] bank_reg [8] = '{default: '0};
    logic       mirror_horiz = 1'b0;
    logic [7:0] wram_ctrl    = '0;
    logic [7:0] irq_period   = '0;
    logic [7:0] irq_cnt      = '0;
    logic       irq_armed    = 1'b0;
    logic       a12_last     = 1'b0;
    logic       irq_flag     = 1'b0;

    t_bus_access pending_q [$];
    t_map_result expected_q [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int mismatches     = 0;
    int accesses_seen  = 0;
    int results_seen   = 0;
    int irq_high_seen  = 0;
    int settings_run   = 0;
    int cycle_count    = 0;

    // Bank shown in one 8 KiB program window; the fixed banks wrap by the
    // same mask as the switchable ones.
    function automatic logic [7:0] prg_window_bank(input logic [1:0] slot);
        logic [31:0] mask;
        logic [7:0]  bank;
        mask = (32'(prg_cnt_cfg) - 32'd1) & 32'hFF & (PRG_BANK_LIMIT - 1);
        case (slot)
            2'd0: bank = sel_reg[6] ? PRG_FIXED_LOW : bank_reg[6];
            2'd1: bank = bank_reg[7];
            2'd2: bank = sel_reg[6] ? bank_reg[6] : PRG_FIXED_LOW;
            default: bank = PRG_FIXED_LAST;
        endcase
        return bank & mask[7:0];
    endfunction

    // Bank shown in one 1 KiB pattern window. The two 2 KiB banks force
    // bit 0 from the window number; select bit 7 swaps the halves.
    function automatic logic [7:0] chr_window_bank(input logic [2:0] slot);
        logic [31:0] mask;
        logic [2:0]  s;
        logic [7:0]  bank;
        mask = (32'(chr_cnt_cfg) - 32'd1) & 32'hFF & (CHR_BANK_LIMIT - 1);
        s = slot ^ {sel_reg[7], 2'b00};
        if (!s[2]) begin
            bank    = bank_reg[{2'b00, s[1]}];
            bank[0] = s[0];
        end else begin
            bank = bank_reg[s - 3'd2];
        end
        return bank & mask[7:0];
    endfunction

    function automatic void tick_scanline();
        if (irq_cnt == 8'd0) irq_cnt = irq_period;
        else irq_cnt = irq_cnt - 8'd1;
        if (irq_cnt == 8'd0 && irq_armed) irq_flag = 1'b1;
    endfunction

    function automatic void write_mapper_reg(input logic [15:0] addr, input logic [7:0] data);
        case ({addr[14:13], addr[0]})
            REG_BANK_SELECT: sel_reg = data;
            REG_BANK_DATA:   bank_reg[sel_reg[2:0]] = data;
            REG_MIRROR:      mirror_horiz = data[0];
            REG_RAM_PROTECT: wram_ctrl = data;
            REG_IRQ_PERIOD:  irq_period = data;
            REG_IRQ_RELOAD:  irq_cnt = 8'd0;
            REG_IRQ_DISABLE: begin
                irq_flag  = 1'b0;
                irq_armed = 1'b0;
            end
            default: irq_armed = 1'b1;
        endcase
    endfunction

    // Map one bus access and advance the mirrored state.
    function automatic t_map_result map_access(input t_bus_access acc);
        t_map_result r;
        logic [31:0] full;
        r        = '0;
        r.target = TGT_NONE;
        if (acc.addr < 16'h2000) begin
            // only pattern reads watch A12
            if (acc.cmd == CMD_READ) begin
                if (!a12_last && acc.addr[12]) tick_scanline();
                a12_last = acc.addr[12];
            end
            full     = 32'(chr_window_bank(acc.addr[12:10])) * 32'h400 + 32'(acc.addr[9:0]);
            r.target = TGT_PATTERN;
            r.maddr  = full[18:0];
            r.wr     = acc.cmd;
        end else if (acc.addr < 16'h3000) begin
            if (four_scr) begin
                full     = 32'(acc.addr) - 32'h2000;
                r.target = TGT_FOUR_SCR;
                r.maddr  = full[18:0];
                r.wr     = acc.cmd;
            end
        end else if (acc.addr >= 16'h6000 && acc.addr < 16'h8000) begin
            // bit 7 opens the RAM, bit 6 blocks writes
            if (wram_ctrl[7] && (acc.cmd == CMD_READ || !wram_ctrl[6])) begin
                full     = 32'(acc.addr) - 32'h6000;
                r.target = TGT_PRG_RAM;
                r.maddr  = full[18:0];
                r.wr     = acc.cmd;
            end
        end else if (acc.addr[15]) begin
            if (acc.cmd == CMD_WRITE) begin
                write_mapper_reg(acc.addr, acc.data);
            end else begin
                full     = 32'(prg_window_bank(acc.addr[14:13])) * 32'h2000
                         + 32'(acc.addr[12:0]);
                r.target = TGT_PRG_ROM;
                r.maddr  = full[18:0];
            end
        end
        r.irq    = irq_flag;
        r.mirror = four_scr ? MIRROR_FOUR : (mirror_horiz ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: take the next item from the pending queue whenever the
    // current one is gone; hold valid and payload until accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bus_access nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                i_in_valid   <= 1'b1;
                i_command    <= nxt.cmd;
                i_address    <= nxt.addr;
                i_write_data <= nxt.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever the
    // stimulus asks for one.
    always @(posedge i_clk) begin
        int stalls_served;
        int stall_left;
        if (!i_rst_n) begin
            i_out_ready   <= 1'b0;
            stalls_served = 0;
            stall_left    = 0;
        end else if (stalls_served != stall_requests) begin
            stalls_served = stalls_served + 1;
            stall_left    = LONG_STALL;
            i_out_ready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: predict on the input handshake first, then check any result
    // taken at the same edge against the oldest prediction.
    always @(posedge i_clk) begin
        t_map_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(map_access({i_command, i_address, i_write_data}));
                accesses_seen++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_irq_line) irq_high_seen++;
                if (expected_q.size() == 0) begin
                    $error("result with no access outstanding");
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("target", want.target, o_target);
                    check_field("mapped_address", want.maddr, o_mapped_address);
                    check_field("mem_write", want.wr, o_mem_write);
                    check_field("irq_line", want.irq, o_irq_line);
                    check_field("mirroring", want.mirror, o_mirroring);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_access(input logic cmd, input logic [15:0] addr,
                                input logic [7:0] data);
        pending_q.push_back({cmd, addr, data});
    endtask

    // Any address in the register window that decodes to the given register.
    function automatic logic [15:0] reg_addr(input logic [2:0] code);
        logic [11:0] fill;
        fill = 12'($urandom);
        return {1'b1, code[2:1], fill, code[0]};
    endfunction

    // Wait until every item is in and every result is out, then let the
    // pipeline settle.
    task automatic wait_idle();
        while (pending_q.size() != 0 || i_in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [6:0] prg, input logic [8:0] chr,
                              input logic four);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PRG_COUNT;
        i_cfg_data  <= {2'b00, prg};
        @(posedge i_clk);
        i_cfg_index <= CFG_CHR_COUNT;
        i_cfg_data  <= chr;
        @(posedge i_clk);
        i_cfg_index <= CFG_FOUR_SCREEN;
        i_cfg_data  <= {8'd0, four};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        prg_cnt_cfg = prg;
        chr_cnt_cfg = chr;
        four_scr    = four;
        settings_run++;
    endtask

    // Random traffic, mostly short well-formed sequences: scanline bursts
    // that toggle A12, IRQ setup, bank programming, guarded RAM access.
    task automatic queue_random(input int count);
        int          made;
        int          len;
        logic        half;
        logic [7:0]  ctrl;
        made = 0;
        while (made < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len  = $urandom_range(4, 12);
                    half = 1'($urandom);
                    for (int k = 0; k < len; k++) begin
                        queue_access(($urandom_range(0, 7) == 0) ? CMD_WRITE : CMD_READ,
                                     {3'b000, half, 12'($urandom)}, 8'($urandom));
                        half = ~half;
                    end
                    made += len;
                end
                3: begin
                    ctrl = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5))
                                                       : 8'($urandom);
                    queue_access(CMD_WRITE, reg_addr(REG_IRQ_PERIOD), ctrl);
                    queue_access(CMD_WRITE, reg_addr(REG_IRQ_RELOAD), 8'($urandom));
                    queue_access(CMD_WRITE, ($urandom_range(0, 3) != 0)
                                 ? reg_addr(REG_IRQ_ENABLE) : reg_addr(REG_IRQ_DISABLE),
                                 8'($urandom));
                    made += 3;
                end
                4: begin
                    queue_access(CMD_WRITE, reg_addr(REG_BANK_SELECT), 8'($urandom));
                    queue_access(CMD_WRITE, reg_addr(REG_BANK_DATA), 8'($urandom));
                    made += 2;
                end
                5: begin
                    ctrl = 8'($urandom);
                    if ($urandom_range(0, 3) != 0) ctrl[7] = 1'b1;
                    queue_access(CMD_WRITE, reg_addr(REG_RAM_PROTECT), ctrl);
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++)
                        queue_access(1'($urandom), 16'h6000 | 16'($urandom_range(0, 16'h1FFF)),
                                     8'($urandom));
                    made += len + 1;
                end
                6: begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++)
                        queue_access(CMD_READ, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                                     8'($urandom));
                    made += len;
                end
                7: begin
                    len = $urandom_range(1, 3);
                    for (int k = 0; k < len; k++)
                        queue_access(1'($urandom), 16'($urandom_range(16'h2000, 16'h5FFF)),
                                     8'($urandom));
                    made += len;
                end
                8: begin
                    queue_access(CMD_WRITE, reg_addr(3'($urandom)), 8'($urandom));
                    made += 1;
                end
                default: begin
                    queue_access(1'($urandom), 16'($urandom), 8'($urandom));
                    made += 1;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles a quarter of the time, receiver most of it.
        send_idle_pct = 24;
        recv_idle_pct = 62;
        set_config(7'd64, 9'd256, 1'b0);

        // Address extremes and every region
        queue_access(CMD_READ,  16'h0000, 8'h00);
        queue_access(CMD_WRITE, 16'h1FFF, 8'hFF);
        queue_access(CMD_READ,  16'hFFFF, 8'h00);
        queue_access(CMD_WRITE, 16'h2000, 8'h12);   // name space, no four-screen RAM
        queue_access(CMD_READ,  16'h3000, 8'h00);   // unmapped
        queue_access(CMD_WRITE, 16'h5FFF, 8'hA5);
        queue_access(CMD_READ,  16'h6000, 8'h00);   // program RAM still closed
        queue_access(CMD_WRITE, reg_addr(REG_RAM_PROTECT), 8'h80);
        queue_access(CMD_READ,  16'h7FFF, 8'h00);
        queue_access(CMD_WRITE, 16'h6000, 8'h5A);
        queue_access(CMD_WRITE, reg_addr(REG_RAM_PROTECT), 8'hC0);
        queue_access(CMD_WRITE, 16'h6001, 8'h33);   // refused: write protected
        // Bank 7 register, program swap mode
        queue_access(CMD_WRITE, reg_addr(REG_BANK_SELECT), 8'h47);
        queue_access(CMD_WRITE, reg_addr(REG_BANK_DATA), 8'hFF);
        queue_access(CMD_READ,  16'hC000, 8'h00);
        // Pattern half swap; this read also clocks the counter with IRQs off
        queue_access(CMD_WRITE, reg_addr(REG_BANK_SELECT), 8'h80);
        queue_access(CMD_READ,  16'h1000, 8'h00);
        queue_access(CMD_WRITE, reg_addr(REG_MIRROR), 8'h01);
        // Counter clear then reload of one; second A12 rise raises the IRQ
        queue_access(CMD_WRITE, reg_addr(REG_IRQ_PERIOD), 8'h01);
        queue_access(CMD_WRITE, reg_addr(REG_IRQ_RELOAD), 8'h00);
        queue_access(CMD_WRITE, reg_addr(REG_IRQ_ENABLE), 8'h00);
        queue_access(CMD_READ,  16'h0000, 8'h00);
        queue_access(CMD_READ,  16'h1000, 8'h00);
        queue_access(CMD_READ,  16'h0400, 8'h00);
        queue_access(CMD_READ,  16'h1400, 8'h00);
        queue_access(CMD_WRITE, reg_addr(REG_IRQ_DISABLE), 8'h00);
        queue_random(380);

        // Phase two: roles swapped, small bank counts, four-screen RAM.
        set_config(7'd2, 9'd8, 1'b1);
        send_idle_pct = 62;
        recv_idle_pct = 24;
        queue_random(330);

        // Phase three: no idling; hold the receiver off for a long stretch
        // while items keep coming, then pause the sender until drained.
        set_config(7'd16, 9'd128, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(120);
        stall_requests++;
        queue_random(120);
        wait_idle();
        queue_random(80);

        // Zero count masks with all ones; odd counts wrap by plain AND.
        set_config(7'd0, 9'd200, 1'b1);
        queue_random(60);
        set_config(7'd127, 9'd0, 1'b0);
        queue_random(50);

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d bus accesses, %0d results checked, over %0d mapper settings",
                 accesses_seen, results_seen, settings_run);
        $display("irq line seen high on %0d results, %0d field mismatches",
                 irq_high_seen, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bmsi_pkg.sv
hw/rtl/bank_mapper_scanline_irq.sv
bench/bank_mapper_scanline_irq_tb.sv
